FILE: rtl/core/acm_pkg.sv
package acm_pkg;

   // Field and storage widths
   localparam int unsigned MAX_CHANNELS  = 8;
   localparam int unsigned CH_BITS       = $clog2(MAX_CHANNELS);
   localparam int unsigned CNT_BITS      = CH_BITS + 1;
   localparam int unsigned SAMPLE_BITS   = 16;
   localparam int unsigned COEF_BITS     = 16;
   localparam int unsigned COEF_FRAC     = 14;
   localparam int unsigned PROD_BITS     = SAMPLE_BITS + COEF_BITS;
   localparam int unsigned ACC_BITS      = PROD_BITS + CH_BITS;
   localparam int unsigned MEM_DEPTH     = MAX_CHANNELS * MAX_CHANNELS;
   localparam int unsigned MEM_ADDR_BITS = 2 * CH_BITS;

   // APB side
   localparam int unsigned CSR_DATA_BITS = 32;
   localparam int unsigned CSR_ADDR_BITS = 3;
   localparam logic [CNT_BITS-1:0] CNT_RESET = CNT_BITS'(2);

   // Register index, taken from paddr[2]
   localparam logic REG_IN_CHANNELS  = 1'b0;
   localparam logic REG_OUT_CHANNELS = 1'b1;

   // Command field codes
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_COEF   = 1'b1;

   typedef struct packed {
      logic [CNT_BITS-1:0] in_ch;
      logic [CNT_BITS-1:0] out_ch;
      logic                clear;
   } csr_cfg_type;

   typedef struct packed {
      logic               issue;
      logic [CH_BITS-1:0] idx;
      logic               clear;
      logic [CH_BITS-1:0] emit_idx;
   } mac_ctrl_type;

   typedef struct packed {
      logic                          busy;
      logic signed [SAMPLE_BITS-1:0] result;
   } mac_stat_type;

endpackage

FILE: rtl/core/acm_ifs.sv
interface acm_req_if import acm_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic                          cmd;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic [CH_BITS-1:0]            coef_row;
   logic [CH_BITS-1:0]            coef_col;
   logic signed [COEF_BITS-1:0]   coef_value;

   modport source (output valid, cmd, sample, coef_row, coef_col, coef_value, input ready);
   modport sink   (input valid, cmd, sample, coef_row, coef_col, coef_value, output ready);
endinterface

interface acm_rsp_if import acm_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic [CH_BITS-1:0]            out_channel;
   logic signed [SAMPLE_BITS-1:0] out_sample;
   logic                          last;

   modport source (output valid, out_channel, out_sample, last, input ready);
   modport sink   (input valid, out_channel, out_sample, last, output ready);
endinterface

FILE: rtl/core/acm_csr.sv
module acm_csr import acm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready,
   output csr_cfg_type              cfg
);

   logic [CNT_BITS-1:0] in_ch_ff, in_ch_in;
   logic [CNT_BITS-1:0] out_ch_ff, out_ch_in;
   logic [CNT_BITS-1:0] wr_cnt;
   logic                wr_en;
   logic                reg_sel;
   logic                clear;

   // 0 acts as 1, anything above the max acts as the max
   function automatic logic [CNT_BITS-1:0] clamp_cnt(input logic [3:0] v);
      logic [CNT_BITS-1:0] r;
      if (v == 4'd0) begin
         r = CNT_BITS'(1);
      end else if (32'(v) > MAX_CHANNELS) begin
         r = CNT_BITS'(MAX_CHANNELS);
      end else begin
         r = CNT_BITS'(v);
      end
      return r;
   endfunction

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_sel = paddr[CSR_ADDR_BITS-1];
   assign wr_cnt  = clamp_cnt(pwdata[3:0]);

   always_comb begin
      in_ch_in  = in_ch_ff;
      out_ch_in = out_ch_ff;
      clear     = 1'b0;
      if (wr_en) begin
         case (reg_sel)
            REG_IN_CHANNELS: begin
               if (wr_cnt != in_ch_ff) begin
                  in_ch_in = wr_cnt;
                  clear    = 1'b1;
               end
            end
            REG_OUT_CHANNELS: begin
               if (wr_cnt != out_ch_ff) begin
                  out_ch_in = wr_cnt;
                  clear     = 1'b1;
               end
            end
            default: begin
               clear = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ch_ff  <= CNT_RESET;
         out_ch_ff <= CNT_RESET;
      end else begin
         in_ch_ff  <= in_ch_in;
         out_ch_ff <= out_ch_in;
      end
   end

   assign prdata = (reg_sel == REG_OUT_CHANNELS) ? CSR_DATA_BITS'(out_ch_ff)
                                                 : CSR_DATA_BITS'(in_ch_ff);

   assign cfg.in_ch  = in_ch_ff;
   assign cfg.out_ch = out_ch_ff;
   assign cfg.clear  = clear;

endmodule

FILE: rtl/core/acm_gain_mem.sv
module acm_gain_mem import acm_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        clear,
   input  logic                        wr_en,
   input  logic [MEM_ADDR_BITS-1:0]    wr_addr,
   input  logic signed [COEF_BITS-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [MEM_ADDR_BITS-1:0]    rd_addr,
   output logic signed [COEF_BITS-1:0] rd_data
);

   logic signed [COEF_BITS-1:0] gain_ff [MEM_DEPTH];
   logic [MEM_DEPTH-1:0]        valid_ff, valid_in;
   logic signed [COEF_BITS-1:0] rd_data_ff;
   logic                        rd_vld_ff;

   // valid bits stand in for the all-zero matrix
   always_comb begin
      valid_in = valid_ff;
      if (clear) begin
         valid_in = '0;
      end else if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (rd_en) begin
            rd_vld_ff <= valid_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         gain_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= gain_ff[rd_addr];
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

FILE: rtl/core/acm_mac.sv
module acm_mac import acm_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  mac_ctrl_type                  ctrl,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic signed [COEF_BITS-1:0]   coef,
   output mac_stat_type                  stat
);

   localparam int unsigned RND_BITS = ACC_BITS + 1;
   localparam logic signed [RND_BITS-1:0] RND_HALF = RND_BITS'(1) << (COEF_FRAC - 1);
   localparam logic signed [RND_BITS-1:0] SAT_HI =
      RND_BITS'(1) << (SAMPLE_BITS - 1 + COEF_FRAC);
   localparam logic signed [RND_BITS-1:0] SAT_LO = -SAT_HI;
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = ~SAMPLE_MAX;

   logic                          s1_v_ff, s2_v_ff;
   logic [CH_BITS-1:0]            s1_idx_ff, s2_idx_ff;
   logic signed [PROD_BITS-1:0]   prod_ff, prod_in;
   logic signed [ACC_BITS-1:0]    acc_ff [MAX_CHANNELS];
   logic signed [RND_BITS-1:0]    rnd;
   logic signed [SAMPLE_BITS-1:0] result;

   assign prod_in = sample * coef;

   // stage 1 lines up with the gain read, stage 2 holds the product
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= ctrl.issue;
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff <= ctrl.idx;
      s2_idx_ff <= s1_idx_ff;
      if (s1_v_ff) begin
         prod_ff <= prod_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            acc_ff[i] <= '0;
         end
      end else if (s2_v_ff) begin
         acc_ff[s2_idx_ff] <= acc_ff[s2_idx_ff] + ACC_BITS'(prod_ff);
      end
   end

   // round half up, drop the fraction bits, saturate
   assign rnd = RND_BITS'(acc_ff[ctrl.emit_idx]) + RND_HALF;

   always_comb begin
      if (rnd >= SAT_HI) begin
         result = SAMPLE_MAX;
      end else if (rnd < SAT_LO) begin
         result = SAMPLE_MIN;
      end else begin
         result = rnd[COEF_FRAC +: SAMPLE_BITS];
      end
   end

   assign stat.result = result;
   assign stat.busy   = s1_v_ff | s2_v_ff;

endmodule

FILE: rtl/core/audio_channel_mix_matrix.sv
// Audio channel mix matrix: one shared 16x16 multiply-accumulate walks the output channels.
// A sample word runs gain read, multiply and accumulate per output channel, then the pipeline
// drains; a coefficient word is taken while idle. On the last input channel of a frame it
// sends out_channels result words, one per cycle while rsp is taken, before it is ready again.
// Reset is synchronous, active high: gain matrix reads as zero (valid bits cleared),
// accumulators and position cleared, both channel counts at 2.
module audio_channel_mix_matrix import acm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   acm_req_if.sink                  req_chan,
   acm_rsp_if.source                rsp_chan,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_MAC  = 3'b010,
      S_EMIT = 3'b100
   } state_type;

   state_type                     state_ff, state_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic [CH_BITS-1:0]            row_ff, row_in;
   logic [CH_BITS-1:0]            rd_idx_ff, rd_idx_in;
   logic                          issue_done_ff, issue_done_in;
   logic                          end_frame_ff, end_frame_in;
   logic [CH_BITS-1:0]            pos_ff, pos_in;
   logic [CH_BITS-1:0]            em_idx_ff, em_idx_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [CH_BITS-1:0]            out_channel_ff, out_channel_in;
   logic signed [SAMPLE_BITS-1:0] out_sample_ff, out_sample_in;
   logic                          last_ff, last_in;

   csr_cfg_type                   cfg;
   mac_ctrl_type                  mac_ctrl;
   mac_stat_type                  mac_stat;
   logic signed [COEF_BITS-1:0]   coef;
   logic [CNT_BITS-1:0]           in_m1, out_m1;
   logic                          req_take;
   logic                          coef_wr;
   logic                          issue;
   logic                          emit_load;
   logic                          emit_last;

   acm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign in_m1  = cfg.in_ch - CNT_BITS'(1);
   assign out_m1 = cfg.out_ch - CNT_BITS'(1);

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_take       = req_chan.valid & req_chan.ready;

   // coefficient words outside the active matrix are dropped
   assign coef_wr = req_take && (req_chan.cmd == CMD_COEF)
                    && ({1'b0, req_chan.coef_row} < cfg.in_ch)
                    && ({1'b0, req_chan.coef_col} < cfg.out_ch);

   // one gain read per cycle while output channels remain to be issued
   assign issue = (state_ff == S_MAC) && !issue_done_ff;

   // entry [row][col] lives at {row, col}
   acm_gain_mem u_gain_mem (
      .clock   (clock),
      .reset   (reset),
      .clear   (cfg.clear),
      .wr_en   (coef_wr),
      .wr_addr ({req_chan.coef_row, req_chan.coef_col}),
      .wr_data (req_chan.coef_value),
      .rd_en   (issue),
      .rd_addr ({row_ff, rd_idx_ff}),
      .rd_data (coef)
   );

   assign emit_load = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_chan.ready);
   assign emit_last = (em_idx_ff == out_m1[CH_BITS-1:0]);

   assign mac_ctrl.issue    = issue;
   assign mac_ctrl.idx      = rd_idx_ff;
   assign mac_ctrl.clear    = cfg.clear | (emit_load & emit_last);
   assign mac_ctrl.emit_idx = em_idx_ff;

   acm_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mac_ctrl),
      .sample (sample_ff),
      .coef   (coef),
      .stat   (mac_stat)
   );

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      sample_in      = sample_ff;
      row_in         = row_ff;
      rd_idx_in      = rd_idx_ff;
      issue_done_in  = issue_done_ff;
      end_frame_in   = end_frame_ff;
      pos_in         = pos_ff;
      em_idx_in      = em_idx_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_chan.ready;
      out_channel_in = out_channel_ff;
      out_sample_in  = out_sample_ff;
      last_in        = last_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_take && (req_chan.cmd == CMD_SAMPLE)) begin
               sample_in     = req_chan.sample;
               // position past the count uses the last row
               row_in        = ({1'b0, pos_ff} >= cfg.in_ch) ? in_m1[CH_BITS-1:0] : pos_ff;
               rd_idx_in     = '0;
               issue_done_in = 1'b0;
               end_frame_in  = (({1'b0, pos_ff} + CNT_BITS'(1)) >= cfg.in_ch);
               state_in      = S_MAC;
            end
         end
         S_MAC: begin
            if (issue) begin
               rd_idx_in = rd_idx_ff + CH_BITS'(1);
               if (rd_idx_ff == out_m1[CH_BITS-1:0]) begin
                  issue_done_in = 1'b1;
               end
            end
            // all products in the accumulators
            if (issue_done_ff && !mac_stat.busy) begin
               if (end_frame_ff) begin
                  em_idx_in = '0;
                  state_in  = S_EMIT;
               end else begin
                  pos_in   = pos_ff + CH_BITS'(1);
                  state_in = S_IDLE;
               end
            end
         end
         S_EMIT: begin
            if (emit_load) begin
               rsp_valid_in   = 1'b1;
               out_channel_in = em_idx_ff;
               out_sample_in  = mac_stat.result;
               last_in        = emit_last;
               if (emit_last) begin
                  pos_in   = '0;
                  state_in = S_IDLE;
               end else begin
                  em_idx_in = em_idx_ff + CH_BITS'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (cfg.clear) begin
         pos_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         issue_done_ff <= 1'b0;
         end_frame_ff  <= 1'b0;
         pos_ff        <= '0;
         em_idx_ff     <= '0;
         rd_idx_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         issue_done_ff <= issue_done_in;
         end_frame_ff  <= end_frame_in;
         pos_ff        <= pos_in;
         em_idx_ff     <= em_idx_in;
         rd_idx_ff     <= rd_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff      <= sample_in;
      row_ff         <= row_in;
      out_channel_ff <= out_channel_in;
      out_sample_ff  <= out_sample_in;
      last_ff        <= last_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_channel = out_channel_ff;
   assign rsp_chan.out_sample  = out_sample_ff;
   assign rsp_chan.last        = last_ff;

endmodule
